[rtl/md5_pkg.sv]
package md5_pkg;

    typedef enum logic [1:0] {
        t_SRC_DATA = 2'd0,
        t_SRC_PAD  = 2'd1,
        t_SRC_ZERO = 2'd2
    } t_byte_src;

    typedef struct packed {
        logic      wr_byte;
        t_byte_src byte_src;
        logic      len_add;
        logic      wr_len;
        logic      comp_load;
        logic      comp_step;
        logic      comp_fold;
        logic      out_load;
        logic      restart;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic       rnd_last;
        logic       out_busy;
    } t_stat;

    localparam logic [31:0] C_INIT_A = 32'h67452301;
    localparam logic [31:0] C_INIT_B = 32'hefcdab89;
    localparam logic [31:0] C_INIT_C = 32'h98badcfe;
    localparam logic [31:0] C_INIT_D = 32'h10325476;

    localparam logic [7:0] C_PAD_BYTE = 8'h80;
    localparam logic [5:0] C_LEN_POS  = 6'd56;
    localparam logic [5:0] C_LAST_POS = 6'd63;

    localparam logic [31:0] C_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] C_SHIFT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [7:0] r8;
        logic [7:0] g8;
        begin
            r8 = {2'b00, rnd};
            unique case (rnd[5:4])
                2'd0: g8 = r8;
                2'd1: g8 = 8'(5 * r8 + 8'd1);
                2'd2: g8 = 8'(3 * r8 + 8'd5);
                default: g8 = 8'(7 * r8);
            endcase
            return g8[3:0];
        end
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] tmp;
        begin
            tmp = {32'd0, v} << n;
            return tmp[63:32] | tmp[31:0];
        end
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

[rtl/md5_ctrl.sv]
module md5_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_has_byte,
    input  logic           i_end_of_message,
    input  md5_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output md5_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD80 = 3'd1;
    localparam logic [2:0] S_PADZ  = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_CLOAD = 3'd4;
    localparam logic [2:0] S_CRUN  = 3'd5;
    localparam logic [2:0] S_CFOLD = 3'd6;
    localparam logic [2:0] S_FINAL = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        o_cmd.byte_src = md5_pkg::t_SRC_DATA;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.wr_byte = i_has_byte;
                    o_cmd.len_add = i_has_byte;
                    if (i_has_byte && i_stat.pos == md5_pkg::C_LAST_POS) begin
                        n_state = S_CLOAD;
                        n_ret   = i_end_of_message ? S_PAD80 : S_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                o_cmd.wr_byte  = 1'b1;
                o_cmd.byte_src = md5_pkg::t_SRC_PAD;
                if (i_stat.pos == md5_pkg::C_LAST_POS) begin
                    n_state = S_CLOAD;
                    n_ret   = S_PADZ;
                end else begin
                    n_state = S_PADZ;
                end
            end
            S_PADZ: begin
                if (i_stat.pos == md5_pkg::C_LEN_POS) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.wr_byte  = 1'b1;
                    o_cmd.byte_src = md5_pkg::t_SRC_ZERO;
                    if (i_stat.pos == md5_pkg::C_LAST_POS) begin
                        n_state = S_CLOAD;
                        n_ret   = S_PADZ;
                    end
                end
            end
            S_LEN: begin
                o_cmd.wr_len = 1'b1;
                n_state      = S_CLOAD;
                n_ret        = S_FINAL;
            end
            S_CLOAD: begin
                o_cmd.comp_load = 1'b1;
                n_state         = S_CRUN;
            end
            S_CRUN: begin
                o_cmd.comp_step = 1'b1;
                if (i_stat.rnd_last) begin
                    n_state = S_CFOLD;
                end
            end
            S_CFOLD: begin
                o_cmd.comp_fold = 1'b1;
                n_state         = r_ret;
            end
            S_FINAL: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.restart  = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

[rtl/md5_dp.sv]
module md5_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_data_byte,
    input  md5_pkg::t_cmd  i_cmd,
    input  logic           i_out_ready,
    output md5_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output logic [63:0]    o_digest_upper,
    output logic [63:0]    o_digest_lower
);

    logic [31:0] r_buf [16];
    logic [5:0]  r_pos;
    logic [63:0] r_len;
    logic [31:0] r_ch_a, r_ch_b, r_ch_c, r_ch_d;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_rnd;
    logic        r_out_valid;
    logic [63:0] r_dig_hi, r_dig_lo;

    logic [7:0]  wr_data;
    logic [3:0]  wr_word;
    logic [1:0]  wr_lane;
    logic [31:0] f_val;
    logic [31:0] t_sum;
    logic [31:0] n_b;

    always_comb begin
        unique case (i_cmd.byte_src)
            md5_pkg::t_SRC_DATA: wr_data = i_data_byte;
            md5_pkg::t_SRC_PAD:  wr_data = md5_pkg::C_PAD_BYTE;
            default:             wr_data = 8'd0;
        endcase
    end

    assign wr_word = r_pos[5:2];
    assign wr_lane = r_pos[1:0];

    always_comb begin
        unique case (r_rnd[5:4])
            2'd0: f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1: f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2: f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
    end

    assign t_sum = f_val + r_a + md5_pkg::C_K[r_rnd] + r_buf[md5_pkg::msg_index(r_rnd)];
    assign n_b   = r_b + md5_pkg::rotl(t_sum, md5_pkg::C_SHIFT[{r_rnd[5:4], r_rnd[1:0]}]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            if (wr_lane == 2'd0) begin
                r_buf[wr_word] <= {24'd0, wr_data};
            end else begin
                r_buf[wr_word][wr_lane*8 +: 8] <= wr_data;
            end
        end
        if (i_cmd.wr_len) begin
            r_buf[14] <= r_len[31:0];
            r_buf[15] <= r_len[63:32];
        end
        if (i_cmd.comp_load) begin
            r_a <= r_ch_a;
            r_b <= r_ch_b;
            r_c <= r_ch_c;
            r_d <= r_ch_d;
        end else if (i_cmd.comp_step) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= n_b;
        end
        if (i_cmd.out_load) begin
            r_dig_hi <= {md5_pkg::bswap(r_ch_a), md5_pkg::bswap(r_ch_b)};
            r_dig_lo <= {md5_pkg::bswap(r_ch_c), md5_pkg::bswap(r_ch_d)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_rnd       <= '0;
            r_ch_a      <= md5_pkg::C_INIT_A;
            r_ch_b      <= md5_pkg::C_INIT_B;
            r_ch_c      <= md5_pkg::C_INIT_C;
            r_ch_d      <= md5_pkg::C_INIT_D;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.restart) begin
                r_pos  <= '0;
                r_len  <= '0;
                r_ch_a <= md5_pkg::C_INIT_A;
                r_ch_b <= md5_pkg::C_INIT_B;
                r_ch_c <= md5_pkg::C_INIT_C;
                r_ch_d <= md5_pkg::C_INIT_D;
            end else begin
                if (i_cmd.wr_byte) begin
                    r_pos <= r_pos + 6'd1;
                end
                if (i_cmd.len_add) begin
                    r_len <= r_len + 64'd8;
                end
                if (i_cmd.comp_fold) begin
                    r_ch_a <= r_ch_a + r_a;
                    r_ch_b <= r_ch_b + r_b;
                    r_ch_c <= r_ch_c + r_c;
                    r_ch_d <= r_ch_d + r_d;
                end
            end
            if (i_cmd.comp_load) begin
                r_rnd <= '0;
            end else if (i_cmd.comp_step) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.pos      = r_pos;
    assign o_stat.rnd_last = (r_rnd == 6'd63);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_digest_upper = r_dig_hi;
    assign o_digest_lower = r_dig_lo;

endmodule

[rtl/md5_message_digest_top.sv]
// Byte items are taken while the controller is idle; the 64th byte of a block adds
// a compression (load, 64 rounds in one shared round unit, chaining fold).
// End-of-message item: byte-serial padding and a length write, with one or two
// compressions in all; the digest is then registered once the output is free.
// Synchronous active-low reset restores the initial chaining words and clears
// length and byte position; the block buffer has no reset.
module md5_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_upper,
    output logic [63:0] o_digest_lower
);

    md5_pkg::t_cmd  cmd;
    md5_pkg::t_stat stat;

    md5_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .i_stat           (stat),
        .o_in_ready       (o_in_ready),
        .o_cmd            (cmd)
    );

    md5_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_data_byte    (i_data_byte),
        .i_cmd          (cmd),
        .i_out_ready    (i_out_ready),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_digest_upper (o_digest_upper),
        .o_digest_lower (o_digest_lower)
    );

endmodule

[sim/tb_md5_message_digest_top.sv]
module tb_md5_message_digest_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 300;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_SLOT = 6'd56;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMT [4][4] = '{
        '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
    };

    typedef struct {
        logic [63:0] upper;
        logic [63:0] lower;
    } t_digest;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_digest_upper;
    logic [63:0] o_digest_lower;

    md5_message_digest_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_upper   (o_digest_upper),
        .o_digest_lower   (o_digest_lower)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predictor state
    logic [31:0] md_chain [4];
    logic [31:0] md_block [16];
    logic [63:0] md_bits;
    logic [5:0]  md_pos;
    t_digest     pending_digests [$];
    t_digest     want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int msgs_sent = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int hold_gen = 0;
    int hold_ack = 0;
    int hold_left = 0;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic void md_restart();
        md_chain[0] = 32'h67452301;
        md_chain[1] = 32'hefcdab89;
        md_chain[2] = 32'h98badcfe;
        md_chain[3] = 32'h10325476;
        md_bits = 64'd0;
        md_pos = 6'd0;
    endfunction

    function automatic void md_compress();
        logic [31:0] a, b, c, d, f, t;
        int r, g;
        a = md_chain[0];
        b = md_chain[1];
        c = md_chain[2];
        d = md_chain[3];
        for (r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = f + a + SINE_K[r] + md_block[g];
            a = d;
            d = c;
            c = b;
            b = b + rol32(t, ROT_AMT[r / 16][r % 4]);
        end
        md_chain[0] += a;
        md_chain[1] += b;
        md_chain[2] += c;
        md_chain[3] += d;
    endfunction

    function automatic void md_put(input logic [7:0] b);
        if (md_pos[1:0] == 2'd0)
            md_block[md_pos[5:2]] = {24'd0, b};
        else
            md_block[md_pos[5:2]][md_pos[1:0] * 8 +: 8] = b;
        md_pos = md_pos + 6'd1;
        if (md_pos == 6'd0)
            md_compress();
    endfunction

    function automatic void predict_md5_item(input logic [7:0] b, input logic hb,
                                             input logic eom);
        logic [63:0] len;
        t_digest res;
        if (hb) begin
            md_put(b);
            md_bits += 64'd8;
        end
        if (eom) begin
            len = md_bits;
            md_put(PAD_MARK);
            while (md_pos != LEN_SLOT)
                md_put(8'd0);
            md_block[14] = len[31:0];
            md_block[15] = len[63:32];
            md_compress();
            res.upper = {byte_rev(md_chain[0]), byte_rev(md_chain[1])};
            res.lower = {byte_rev(md_chain[2]), byte_rev(md_chain[3])};
            pending_digests = {pending_digests, res};
            md_restart();
        end
    endfunction

    // results are checked before the same edge's input is folded in
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_digests.size() == 0) begin
                $display("%0t: digest with none expected: got %h %h", $time,
                         o_digest_upper, o_digest_lower);
                mismatches++;
            end else begin
                want = pending_digests.pop_front();
                if (o_digest_upper !== want.upper) begin
                    $display("%0t: digest_upper mismatch: expected %h actual %h", $time,
                             want.upper, o_digest_upper);
                    mismatches++;
                end
                if (o_digest_lower !== want.lower) begin
                    $display("%0t: digest_lower mismatch: expected %h actual %h", $time,
                             want.lower, o_digest_lower);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready)
            predict_md5_item(i_data_byte, i_has_byte, i_end_of_message);
    end

    always @(posedge i_clk) begin
        if (hold_gen != hold_ack) begin
            hold_ack <= hold_gen;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_has_byte <= hb;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        int i;
        logic byte_on_end;
        byte_on_end = (len > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, byte_on_end && (i == len - 1));
        end
        if (!byte_on_end)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        msgs_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_digests.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_known_vectors();
        send_item(8'h00, 1'b0, 1'b1);
        send_item("a", 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        wait_drained();
    endtask

    // padding fits, no room for the length, full block, block plus one
    task automatic test_block_boundaries();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        send_message(65);
        wait_drained();
    endtask

    task automatic test_random_messages(input int snd_pct, input int rcv_pct,
                                        input int n_items, input int n_msgs);
        int item_goal, msg_goal, pick;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        item_goal = items_sent + n_items;
        msg_goal = msgs_sent + n_msgs;
        while (items_sent < item_goal || msgs_sent < msg_goal) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_message($urandom_range(8));
            else if (pick < 80)
                send_message($urandom_range(72, 52));
            else if (pick < 95)
                send_message($urandom_range(140));
            else
                send_message($urandom_range(200, 120));
        end
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        int k;
        hold_gen++;
        for (k = 0; k < 8; k++)
            send_message($urandom_range(3));
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_message($urandom_range(20));
        wait_drained();
        send_message($urandom_range(70, 50));
        wait_drained();
    endtask

    initial begin
        md_restart();
        send_idle_pct = 13;
        recv_idle_pct = 60;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_known_vectors();
        test_block_boundaries();
        test_random_messages(13, 60, 50, 2);
        test_output_hold_off();
        test_random_messages(60, 13, 50, 2);
        test_drain_pause();
        test_random_messages(0, 0, 50, 2);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_digests.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
